// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// File: hw/rtl/isogv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isogv_pkg
// Types and constants of the isometric grid nearest-vertex picker.
// ----------------------------------------------------------------------------
package isogv_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd2;

  localparam logic [15:0] DELTA_X_RST   = 16'd12288;
  localparam logic [15:0] DELTA_Y_RST   = 16'd6144;
  localparam logic [7:0]  GRID_SIZE_RST = 8'd32;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [23:0] screen_x;
    logic signed [23:0] screen_y;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic               inside_res;
    logic [7:0]         vertex_row;
    logic [7:0]         vertex_col;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
  } out_item_t;

  // Offset of the point from the origin, and the origin itself.
  typedef struct packed {
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [23:0] ox;
    logic signed [23:0] oy;
  } geo_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic       in_grid;
    logic [7:0] cr;
    logic [7:0] cc;
    geo_t       geo;
  } task_t;

endpackage

// File: hw/rtl/isogv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isogv_front
// Inverse isometric map: offsets, products, bit-per-stage division and the
// inside test with rounding to the centre vertex.
// ----------------------------------------------------------------------------
module isogv_front import isogv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  input  logic [15:0] ddx,
  input  logic [15:0] ddy,
  input  logic [7:0]  gsz,
  input  logic        q_full,
  output logic        q_push,
  output task_t       q_item
);

  localparam int QW = FRAC_BITS + 9;

  logic en;
  logic v1, v2, vf;
  geo_t geo1, geo2;
  logic signed [41:0] p1, p2;
  logic [31:0] dprod;
  logic [32:0] den_q;
  logic signed [41:0] numc, numr;

  logic          vd    [0:QW];
  geo_t          geod  [0:QW];
  logic [32:0]   rem_c [0:QW];
  logic [32:0]   rem_r [0:QW];
  logic [8:0]    low_c [0:QW];
  logic [8:0]    low_r [0:QW];
  logic          bad_c [0:QW];
  logic          bad_r [0:QW];
  logic [QW-1:0] quo_c [0:QW];
  logic [QW-1:0] quo_r [0:QW];

  logic [QW-1:0] lim;
  logic [QW:0]   sum_c, sum_r;
  logic          in_grid;
  task_t         fitem;

  assign en       = !vf || !q_full;
  assign in_ready = en;
  assign q_push   = vf && !q_full;
  assign q_item   = fitem;

  assign dprod = ddx * ddy;

  always_ff @(posedge clk) begin
    den_q <= {dprod, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vd[0] <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      vd[0] <= v2;
    end
  end

  assign numc = p1 + p2;
  assign numr = p1 - p2;

  always_ff @(posedge clk) begin
    if (en) begin
      geo1.dx <= $signed({in_item.screen_x[23], in_item.screen_x})
               - $signed({in_item.origin_x[23], in_item.origin_x});
      geo1.dy <= $signed({in_item.screen_y[23], in_item.screen_y})
               - $signed({in_item.origin_y[23], in_item.origin_y});
      geo1.ox <= in_item.origin_x;
      geo1.oy <= in_item.origin_y;
      geo2    <= geo1;
      p1      <= geo1.dx * $signed({1'b0, ddy});
      p2      <= geo1.dy * $signed({1'b0, ddx});
      geod[0] <= geo2;
      // A negative numerator floors below zero; a quotient of 2^(8+F+1) or more
      // is beyond any grid size, so both are outside before dividing.
      bad_c[0] <= numc[41] || (numc >= {den_q, 9'b0});
      bad_r[0] <= numr[41] || (numr >= {den_q, 9'b0});
      rem_c[0] <= {1'b0, numc[40:9]};
      rem_r[0] <= {1'b0, numr[40:9]};
      low_c[0] <= numc[8:0];
      low_r[0] <= numr[8:0];
      quo_c[0] <= '0;
      quo_r[0] <= '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int B = QW - 1 - s;
    logic        nb_c, nb_r;
    logic [33:0] tr_c, tr_r;
    logic        ge_c, ge_r;

    if (B >= FRAC_BITS) begin : g_bit
      assign nb_c = low_c[s][B-FRAC_BITS];
      assign nb_r = low_r[s][B-FRAC_BITS];
    end else begin : g_zero
      assign nb_c = 1'b0;
      assign nb_r = 1'b0;
    end

    assign tr_c = {rem_c[s], nb_c};
    assign tr_r = {rem_r[s], nb_r};
    assign ge_c = tr_c >= {1'b0, den_q};
    assign ge_r = tr_r >= {1'b0, den_q};

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[s+1] <= 1'b0;
      end else if (en) begin
        vd[s+1] <= vd[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        geod[s+1]  <= geod[s];
        bad_c[s+1] <= bad_c[s];
        bad_r[s+1] <= bad_r[s];
        low_c[s+1] <= low_c[s];
        low_r[s+1] <= low_r[s];
        rem_c[s+1] <= ge_c ? 33'(tr_c - {1'b0, den_q}) : tr_c[32:0];
        rem_r[s+1] <= ge_r ? 33'(tr_r - {1'b0, den_q}) : tr_r[32:0];
        quo_c[s+1] <= {quo_c[s][QW-2:0], ge_c};
        quo_r[s+1] <= {quo_r[s][QW-2:0], ge_r};
      end
    end
  end

  assign lim     = {1'b0, gsz, {FRAC_BITS{1'b0}}};
  assign in_grid = !bad_c[QW] && !bad_r[QW] && (quo_c[QW] <= lim) && (quo_r[QW] <= lim);
  // Round half up to the centre vertex.
  assign sum_c  = {1'b0, quo_c[QW]} + ((QW+1)'(1) << (FRAC_BITS - 1));
  assign sum_r  = {1'b0, quo_r[QW]} + ((QW+1)'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= vd[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fitem.in_grid <= in_grid;
      fitem.cr      <= sum_r[FRAC_BITS+7:FRAC_BITS];
      fitem.cc      <= sum_c[FRAC_BITS+7:FRAC_BITS];
      fitem.geo     <= geod[QW];
    end
  end

endmodule

// File: hw/rtl/isogv_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isogv_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module isogv_fifo import isogv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  task_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output task_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  task_t            mem [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count;

  assign full     = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign head     = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// File: hw/rtl/isogv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isogv_back
// Scores the 3x3 vertices round the centre and registers the nearest one.
// ----------------------------------------------------------------------------
module isogv_back import isogv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] ddx,
  input  logic [15:0] ddy,
  input  logic [7:0]  gsz,
  input  logic        q_nonempty,
  output logic        q_pop,
  input  task_t       q_head,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  typedef logic [4:0][28:0] pos5_t;

  typedef struct packed {
    logic        ok;
    logic [56:0] d;
    logic [7:0]  r;
    logic [7:0]  c;
    logic [2:0]  kx;
    logic [2:0]  ky;
  } cand_t;

  // Earlier candidate wins ties.
  function automatic cand_t pick(cand_t a, cand_t b);
    cand_t w;
    w = a;
    if (b.ok && (!a.ok || (b.d < a.d))) begin
      w = b;
    end
    return w;
  endfunction

  logic en;
  logic v1, v2, v3, v4, v5, v6, v7, v8, ov;
  logic ins1, ins2, ins3, ins4, ins5, ins6, ins7, ins8;
  task_t t1;
  logic [7:0] cr2, cc2, cr3, cc3;
  logic [2:0] rok1, cok1, rok2, cok2, rok3, cok3;
  logic signed [27:0] px1 [0:4];
  logic signed [26:0] py1 [0:4];
  logic signed [28:0] ex2 [0:4];
  logic signed [28:0] ey2 [0:4];
  logic [55:0] sqx3 [0:4];
  logic [55:0] sqy3 [0:4];
  pos5_t vx2, vy2, vx3, vy3, vx4, vy4, vx5, vy5, vx6, vy6, vx7, vy7, vx8, vy8;
  cand_t c4 [0:8];
  cand_t c5 [0:4];
  cand_t c6 [0:2];
  cand_t c7 [0:1];
  cand_t c8;
  out_item_t oitem;

  assign en        = !ov || out_ready;
  assign q_pop     = en && q_nonempty;
  assign out_valid = ov;
  assign out_item  = oitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; ov <= 1'b0;
    end else if (en) begin
      v1 <= q_nonempty;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; ov <= v8;
    end
  end

  // Stage 1: lane offsets times the steps; row and column range checks.
  for (genvar k = 0; k < 5; k++) begin : g_lane
    logic signed [10:0] mx;
    logic signed [9:0]  my;
    logic signed [57:0] px_sq, py_sq;

    assign mx = $signed({3'b0, q_head.cr}) + $signed({3'b0, q_head.cc})
              + 11'(k) - 11'sd2;
    assign my = $signed({2'b0, q_head.cc}) - $signed({2'b0, q_head.cr})
              + 10'(k) - 10'sd2;
    assign px_sq = ex2[k] * ex2[k];
    assign py_sq = ey2[k] * ey2[k];

    always_ff @(posedge clk) begin
      if (en) begin
        px1[k] <= mx * $signed({1'b0, ddx});
        py1[k] <= my * $signed({1'b0, ddy});
        vx2[k] <= t1.geo.ox + px1[k];
        vy2[k] <= t1.geo.oy + py1[k];
        ex2[k] <= px1[k] - t1.geo.dx;
        ey2[k] <= py1[k] - t1.geo.dy;
        sqx3[k] <= px_sq[55:0];
        sqy3[k] <= py_sq[55:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1   <= q_head;
      ins1 <= q_head.in_grid;
      rok1 <= {q_head.cr < gsz, 1'b1, q_head.cr != 8'd0};
      cok1 <= {q_head.cc < gsz, 1'b1, q_head.cc != 8'd0};
      ins2 <= ins1; cr2 <= t1.cr; cc2 <= t1.cc; rok2 <= rok1; cok2 <= cok1;
      ins3 <= ins2; cr3 <= cr2; cc3 <= cc2; rok3 <= rok2; cok3 <= cok2;
      vx3 <= vx2; vy3 <= vy2;
      ins4 <= ins3; vx4 <= vx3; vy4 <= vy3;
      ins5 <= ins4; vx5 <= vx4; vy5 <= vy4;
      ins6 <= ins5; vx6 <= vx5; vy6 <= vy5;
      ins7 <= ins6; vx7 <= vx6; vy7 <= vy6;
      ins8 <= ins7; vx8 <= vx7; vy8 <= vy7;
    end
  end

  // Stage 4: distance of each of the nine vertices, row-major.
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          c4[3*i+j].ok <= rok3[i] && cok3[j];
          c4[3*i+j].d  <= {1'b0, sqx3[i+j]} + {1'b0, sqy3[j-i+2]};
          c4[3*i+j].r  <= cr3 + 8'(i) - 8'd1;
          c4[3*i+j].c  <= cc3 + 8'(j) - 8'd1;
          c4[3*i+j].kx <= 3'(i + j);
          c4[3*i+j].ky <= 3'(j - i + 2);
        end
      end
    end
  end

  // Registered minimum tree, order kept so ties go to the earlier vertex.
  always_ff @(posedge clk) begin
    if (en) begin
      c5[0] <= pick(c4[0], c4[1]);
      c5[1] <= pick(c4[2], c4[3]);
      c5[2] <= pick(c4[4], c4[5]);
      c5[3] <= pick(c4[6], c4[7]);
      c5[4] <= c4[8];
      c6[0] <= pick(c5[0], c5[1]);
      c6[1] <= pick(c5[2], c5[3]);
      c6[2] <= c5[4];
      c7[0] <= pick(c6[0], c6[1]);
      c7[1] <= c6[2];
      c8    <= pick(c7[0], c7[1]);
    end
  end

  // The positions span at most 27 bits, so sign extension to 32 bits keeps them exact.
  always_ff @(posedge clk) begin
    if (en) begin
      if (ins8) begin
        oitem.inside_res <= 1'b1;
        oitem.vertex_row <= c8.r;
        oitem.vertex_col <= c8.c;
        oitem.vertex_x   <= $signed(vx8[c8.kx]);
        oitem.vertex_y   <= $signed(vy8[c8.ky]);
      end else begin
        oitem <= '0;
      end
    end
  end

endmodule

// File: hw/rtl/iso_grid_nearest_vertex_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso_grid_nearest_vertex_unit
// Picks the isometric grid vertex nearest to a screen point.
// ----------------------------------------------------------------------------
// One request is taken every clock unless a held output backs the queue up
// and stalls the front. The two divider pipelines resolve one quotient bit
// per stage, FRAC_BITS + 9 stages in all, FRAC_BITS being 8 fraction bits by
// default. Register writes are to be made only while no request is in flight.
`include "assert_macros.svh"

module iso_grid_nearest_vertex_unit import isogv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0] delta_x, delta_y, ddx, ddy;
  logic [7:0]  grid_size;
  logic        q_full, q_push, q_pop, q_nonempty;
  task_t       q_in, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_x   <= DELTA_X_RST;
      delta_y   <= DELTA_Y_RST;
      grid_size <= GRID_SIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DELTA_X:   delta_x   <= cfg_data;
        CFG_DELTA_Y:   delta_y   <= cfg_data;
        CFG_GRID_SIZE: grid_size <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A zero step behaves as one.
  assign ddx = (delta_x == 16'd0) ? 16'd1 : delta_x;
  assign ddy = (delta_y == 16'd0) ? 16'd1 : delta_y;

  isogv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .ddx      (ddx),
    .ddy      (ddy),
    .gsz      (grid_size),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  isogv_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  isogv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .ddx        (ddx),
    .ddy        (ddy),
    .gsz        (grid_size),
    .q_nonempty (q_nonempty),
    .q_pop      (q_pop),
    .q_head     (q_head),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  `ASSERT_RST(a_outside_zero, clk, rst, (out_valid && !out_item.inside_res) |-> (out_item.vertex_row == 8'd0 && out_item.vertex_col == 8'd0 && out_item.vertex_x == 32'sd0 && out_item.vertex_y == 32'sd0), "outside result carries non-zero fields")
  `ASSERT_RST(a_vertex_in_grid, clk, rst, (out_valid && out_item.inside_res) |-> (out_item.vertex_row <= grid_size && out_item.vertex_col <= grid_size), "chosen vertex lies beyond the grid")
  `ASSERT_NEXT(a_queue_drains, clk, rst, q_nonempty && !q_push && q_pop && !q_full, !q_full, "queue full after a pop without a push")

endmodule
